>>> rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor and scroll block.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 24;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR = 1'd1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } out_item_t;

  // request from control to the cursor unit
  typedef struct packed {
    logic       put;
    logic [7:0] char_code;
  } tcc_cmd_t;

  // cursor unit view for the beat being accepted
  typedef struct packed {
    logic       wr_en;
    logic       scroll;
    logic [4:0] row;
    logic [6:0] col;
  } tcc_stat_t;

endpackage

>>> rtl/core/tcc_ram.sv
// ----------------------------------------------------------------------------
// tcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/tcc_cursor.sv
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor, tab phase and ring base of the row store; maps console rows to
// physical rows and computes the cursor move for a put.
// ----------------------------------------------------------------------------
module tcc_cursor
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcc_cmd_t                         cmd,
  input  logic [4:0]                       read_row,
  input  logic [6:0]                       read_col,
  output tcc_stat_t                        stat,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  wr_addr,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  blank_addr,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  rd_addr,
  output logic                             rd_ok
);

  localparam int LW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLUMNS);
  localparam int TW  = $clog2(TAB_STOP);
  localparam int CXW = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int AW  = $clog2(ROWS * COLUMNS);
  localparam int SW  = ((LW > 5) ? LW : 5) + 1;

  logic [LW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [TW-1:0] phase_r, phase_nxt;   // col_r mod TAB_STOP
  logic [LW-1:0] base_r, base_nxt;     // physical row of console row 0

  logic [CXW-1:0] ncol;
  logic           line_inc;
  logic           printable;
  logic           scroll;
  logic [LW:0]    cur_sum;
  logic [LW-1:0]  cur_phys;
  logic [SW-1:0]  rd_sum;
  logic [LW-1:0]  rd_phys;

  always_comb begin
    ncol      = CXW'(col_r);
    line_inc  = 1'b0;
    printable = 1'b0;
    phase_nxt = phase_r;
    case (cmd.char_code)
      CH_NEWLINE: begin
        ncol      = '0;
        line_inc  = 1'b1;
        phase_nxt = '0;
      end
      CH_RETURN: begin
        ncol      = '0;
        phase_nxt = '0;
      end
      CH_TAB: begin
        ncol      = CXW'(col_r) - CXW'(phase_r) + CXW'(TAB_STOP);
        phase_nxt = '0;
      end
      default: begin
        printable = 1'b1;
        ncol      = CXW'(col_r) + CXW'(1);
        phase_nxt = (phase_r == TW'(TAB_STOP - 1)) ? '0 : phase_r + TW'(1);
      end
    endcase
    if (ncol >= CXW'(COLUMNS)) begin
      ncol      = '0;
      line_inc  = 1'b1;
      phase_nxt = '0;
    end
    col_nxt  = CW'(ncol);
    scroll   = line_inc && (line_r == LW'(ROWS - 1));
    line_nxt = (line_inc && !scroll) ? line_r + LW'(1) : line_r;
    base_nxt = !scroll ? base_r : ((base_r == LW'(ROWS - 1)) ? '0 : base_r + LW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      col_r   <= '0;
      phase_r <= '0;
      base_r  <= '0;
    end else if (cmd.put) begin
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
    end
  end

  // ring mapping: console row r lives at physical row (r + base) mod ROWS
  always_comb begin
    cur_sum  = (LW+1)'(line_r) + (LW+1)'(base_r);
    cur_phys = (cur_sum >= (LW+1)'(ROWS)) ? LW'(cur_sum - (LW+1)'(ROWS)) : LW'(cur_sum);
    rd_sum   = SW'(read_row) + SW'(base_r);
    rd_phys  = (rd_sum >= SW'(ROWS)) ? LW'(rd_sum - SW'(ROWS)) : LW'(rd_sum);
  end

  assign wr_addr    = AW'(cur_phys) * AW'(COLUMNS) + AW'(col_r);
  assign blank_addr = AW'(base_r) * AW'(COLUMNS);  // old top row becomes new bottom
  assign rd_addr    = AW'(rd_phys) * AW'(COLUMNS) + AW'(read_col);
  assign rd_ok      = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

  assign stat.wr_en  = cmd.put && printable;
  assign stat.scroll = cmd.put && scroll;
  assign stat.row    = cmd.put ? 5'(line_nxt) : 5'(line_r);
  assign stat.col    = cmd.put ? 7'(col_nxt) : 7'(col_r);

endmodule

>>> rtl/core/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell text console with cursor, wrap and scroll over a row store.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_item when start is high and busy is low. Each beat
//   gives exactly one result on out_item, marked by a one-cycle out_valid;
//   the receiver always takes it.
//   Put (cmd 0): a printable character is written to the cell at the cursor;
//   result in the next cycle, next command accepted in the next cycle.
//   Put that scrolls: the row store is a ring of rows, so a scroll bumps the
//   ring base and blanks the new bottom row with one write per cycle; busy
//   while that row is blanked, result registered after the last blank write.
//   Read (cmd 1): one registered RAM read; the result goes through the read
//   state, and the next command is accepted once that state is over.
//   Puts while enabled is 0 change nothing and answer in the next cycle.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is written while cfg_we is high and
//   is meant to be written with no command in flight.
//   Reset: a clearing pass writes a blank with attribute 7 into every cell,
//   ROWS*COLUMNS cells (1920 at 80x24); busy stays high until it is done.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(ROWS * COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } state_t;

  state_t          state_r, state_nxt;
  logic            enabled_r;
  logic [7:0]      text_attr_r;
  logic [AW-1:0]   sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]   sweep_last_r, sweep_last_nxt;
  logic [15:0]     sweep_cell_r, sweep_cell_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            accept;
  logic            sweeping;
  tcc_cmd_t        cur_cmd;
  tcc_stat_t       cur_stat;
  logic [AW-1:0]   cur_wr_addr;
  logic [AW-1:0]   blank_addr;
  logic [AW-1:0]   rd_addr;
  logic            rd_ok;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [15:0]     ram_rdata;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign sweeping = (state_r == ST_CLEAR) || (state_r == ST_BLANK);

  assign cur_cmd.put       = accept && (in_item.cmd == CMD_PUT) && enabled_r;
  assign cur_cmd.char_code = in_item.char_code;

  tcc_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cur_cmd),
    .read_row   (in_item.read_row),
    .read_col   (in_item.read_col),
    .stat       (cur_stat),
    .wr_addr    (cur_wr_addr),
    .blank_addr (blank_addr),
    .rd_addr    (rd_addr),
    .rd_ok      (rd_ok)
  );

  // puts write in the accept cycle; sweep writes come only while busy, so no overlap
  assign ram_we    = sweeping || cur_stat.wr_en;
  assign ram_waddr = sweeping ? sweep_addr_r : cur_wr_addr;
  assign ram_wdata = sweeping ? sweep_cell_r : {text_attr_r, in_item.char_code};

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    sweep_cell_nxt = sweep_cell_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (accept) begin
          out_nxt.cursor_row = cur_stat.row;
          out_nxt.cursor_col = cur_stat.col;
          out_nxt.cell_char  = '0;
          out_nxt.cell_attr  = '0;
          out_nxt.scrolled   = cur_stat.scroll;
          if (in_item.cmd == CMD_READ) begin
            rd_ok_nxt = rd_ok;
            state_nxt = ST_READ;
          end else if (cur_stat.scroll) begin
            sweep_addr_nxt = blank_addr;
            sweep_last_nxt = blank_addr + AW'(COLUMNS - 1);
            sweep_cell_nxt = {text_attr_r, CH_SPACE};
            state_nxt      = ST_BLANK;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_nxt.cell_char = rd_ok_r ? ram_rdata[7:0]  : 8'h00;
        out_nxt.cell_attr = rd_ok_r ? ram_rdata[15:8] : 8'h00;
        out_valid_nxt     = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_CLEAR, ST_BLANK: begin
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == sweep_last_r) begin
          out_valid_nxt = (state_r == ST_BLANK);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sweep_addr_r <= '0;
      sweep_last_r <= AW'(DEPTH - 1);
      sweep_cell_r <= {ATTR_RESET, CH_SPACE};
      rd_ok_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      sweep_cell_r <= sweep_cell_nxt;
      rd_ok_r      <= rd_ok_nxt;
      out_valid_r  <= out_valid_nxt;
      out_r        <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      text_attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:   enabled_r   <= cfg_wdata[0];
        CFG_TEXT_ATTR: text_attr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> rtl/core/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level assertions for the text console, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker
  import tcc_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_item,
  input logic                  out_valid,
  input out_item_t             out_item,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // clearing pass holds off commands right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // a read beat answers once its read state is over, with the scrolled flag low
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == CMD_READ) |=> ##1 (out_valid && !out_item.scrolled))
    else $error("read result missing two cycles after beat");

  // a read beat leaves the block busy, with no result yet, in the cycle after the beat
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == CMD_READ) |=> (busy && !out_valid))
    else $error("read beat did not hold busy");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.scrolled) |-> (out_item.cursor_row == 5'(ROWS - 1)))
    else $error("scroll left cursor off the bottom row");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

endmodule

bind text_console_cursor_scroll tcc_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcc_checker (.*);

>>> tb/tb_text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console: a shadow console predicts the
// cursor, scroll flag and read-back cell of every command beat, and each
// out_valid strobe is checked in order against the oldest prediction.
// Directed beats cover reset contents, out-of-range reads, disabled puts,
// byte extremes and control codes; random phases then run under several
// enable and attribute settings.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
  import tcc_pkg::*;

  localparam int CELLS      = ROWS_DEF * COLUMNS_DEF;
  localparam int SCROLL_LAT = COLUMNS_DEF + 4;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow console
  logic [15:0] cell_shadow [CELLS];
  int          cur_line;
  int          cur_col;
  logic        con_enabled;
  logic [7:0]  con_attr;

  out_item_t   pending_results [$];
  int          err_count;
  bit          no_gaps;

  text_console_cursor_scroll u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void shadow_reset();
    for (int i = 0; i < CELLS; i++) cell_shadow[i] = {ATTR_RESET, CH_SPACE};
    cur_line    = 0;
    cur_col     = 0;
    con_enabled = 1'b0;
    con_attr    = ATTR_RESET;
  endfunction

  function automatic void shadow_scroll();
    for (int i = 0; i < (ROWS_DEF - 1) * COLUMNS_DEF; i++)
      cell_shadow[i] = cell_shadow[i + COLUMNS_DEF];
    for (int c = 0; c < COLUMNS_DEF; c++)
      cell_shadow[(ROWS_DEF - 1) * COLUMNS_DEF + c] = {con_attr, CH_SPACE};
  endfunction

  function automatic out_item_t console_step(in_item_t it);
    out_item_t r;
    int        t;
    r = '0;
    if (it.cmd == CMD_READ) begin
      if (it.read_row < ROWS_DEF && it.read_col < COLUMNS_DEF)
        {r.cell_attr, r.cell_char} = cell_shadow[it.read_row * COLUMNS_DEF + it.read_col];
    end else if (con_enabled) begin
      case (it.char_code)
        CH_NEWLINE: begin
          cur_line++;
          cur_col = 0;
        end
        CH_RETURN: cur_col = 0;
        CH_TAB: begin
          t = cur_col + TAB_STOP_DEF;
          cur_col = t - (t % TAB_STOP_DEF);
        end
        default: begin
          if (cur_line < ROWS_DEF && cur_col < COLUMNS_DEF)
            cell_shadow[cur_line * COLUMNS_DEF + cur_col] = {con_attr, it.char_code};
          cur_col++;
        end
      endcase
      if (cur_col >= COLUMNS_DEF) begin
        cur_col = 0;
        cur_line++;
      end
      if (cur_line >= ROWS_DEF) begin
        shadow_scroll();
        cur_line   = ROWS_DEF - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_row = cur_line[4:0];
    r.cursor_col = cur_col[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // result checker: every strobe is taken at the edge that ends its cycle
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_item, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", out_item.cursor_row, want.cursor_row);
        if (out_item.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", out_item.cursor_col, want.cursor_col);
        if (out_item.cell_char !== want.cell_char)
          report_mismatch("cell_char", out_item.cell_char, want.cell_char);
        if (out_item.cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", out_item.cell_attr, want.cell_attr);
        if (out_item.scrolled !== want.scrolled)
          report_mismatch("scrolled", out_item.scrolled, want.scrolled);
      end
    end
  end

  function automatic in_item_t mk_put(logic [7:0] ch);
    in_item_t it;
    it.cmd       = CMD_PUT;
    it.char_code = ch;
    it.read_row  = 5'($urandom_range(0, 31));
    it.read_col  = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic in_item_t mk_read(int row, int col);
    in_item_t it;
    it.cmd       = CMD_READ;
    it.char_code = 8'($urandom_range(0, 255));
    it.read_row  = 5'(row);
    it.read_col  = 7'(col);
    return it;
  endfunction

  // start stays high across back-to-back beats; send_item lowers it only for a gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(console_step(it));
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_console(logic en, logic [7:0] attr);
    logic [CFG_DATA_W-1:0] en_word;
    quiesce();
    en_word = {7'($urandom_range(0, 127)), en};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= en_word;
    @(posedge clk);
    con_enabled = en_word[0];
    cfg_index <= CFG_TEXT_ATTR;
    cfg_wdata <= attr;
    @(posedge clk);
    con_attr = attr;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(mk_read(0, 0));
    send_item(mk_read(ROWS_DEF - 1, COLUMNS_DEF - 1));
    send_item(mk_read(31, 0));     // row past the store
    send_item(mk_read(0, 127));    // column past the row
  endtask

  task automatic test_disabled_put();
    send_item(mk_put("X"));
    send_item(mk_put(CH_NEWLINE));
  endtask

  task automatic test_controls();
    program_console(1'b1, 8'h00);
    send_item(mk_put(8'h00));
    send_item(mk_put(8'hFF));
    send_item(mk_read(0, 0));
    send_item(mk_read(0, 1));
    send_item(mk_put(CH_TAB));
    send_item(mk_put(CH_RETURN));
    send_item(mk_put(CH_NEWLINE));
  endtask

  // tab from the last stop lands past the edge and must wrap
  task automatic test_tab_wrap();
    program_console(1'b1, 8'hFF);
    send_item(mk_put(CH_RETURN));
    for (int i = 0; i < COLUMNS_DEF / TAB_STOP_DEF; i++) send_item(mk_put(CH_TAB));
    send_item(mk_read(cur_line, 0));
  endtask

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8)       return CH_NEWLINE;
    else if (k < 12) return CH_RETURN;
    else if (k < 18) return CH_TAB;
    else if (k < 30) return 8'($urandom_range(0, 255));
    else             return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic in_item_t rand_item();
    int k;
    int row;
    int col;
    k = $urandom_range(0, 99);
    if (k >= 25) return mk_put(rand_char());
    k   = $urandom_range(0, 99);
    row = (k < 40) ? cur_line : (k < 90) ? $urandom_range(0, ROWS_DEF - 1)
                                          : $urandom_range(0, 31);
    col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                      : $urandom_range(0, COLUMNS_DEF - 1);
    return mk_read(row, col);
  endfunction

  task automatic test_random_phase(int n, logic en, logic [7:0] attr);
    program_console(en, attr);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_item(rand_item());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= '0;
    err_count = 0;
    no_gaps   = 1'b0;
    shadow_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // clearing pass after reset
    do @(posedge clk); while (busy !== 1'b0);

    test_reset_state();
    test_disabled_put();
    test_controls();
    test_tab_wrap();
    test_random_phase(400, 1'b1, 8'($urandom_range(0, 255)));
    test_random_phase(300, 1'b1, 8'hFF);
    test_random_phase(100, 1'b0, 8'($urandom_range(0, 255)));
    test_random_phase(300, 1'b1, 8'h00);
    test_random_phase(400, 1'b1, 8'($urandom_range(0, 255)));
    test_random_phase(400, 1'b1, ATTR_RESET);

    quiesce();
    repeat (SCROLL_LAT) @(posedge clk);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
